@@ src/filtered_mean_median_mode_top_macros.svh @@
// assertion macros for the top rtl module
// expects clk and arst_n in the scope of each use
`ifndef FILTERED_MEAN_MEDIAN_MODE_TOP_MACROS_SVH
`define FILTERED_MEAN_MEDIAN_MODE_TOP_MACROS_SVH

// property checked on every rising clock edge outside reset
`define FMMM_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// condition that must never be true outside reset
`define FMMM_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

@@ src/fmmm_pkg.sv @@
// shared types and constants for the filtered mean/median/mode block
// no dependencies
`timescale 1ns / 1ps

package fmmm_pkg;

	localparam int MAX_VALUES_DEF = 256;
	localparam int VAL_W = 32;
	localparam int KEY_W = 24;
	localparam int SUM_W = 40;
	localparam int CNT_OUT_W = 9;

	// value handed between neighboring cells
	typedef struct packed {
		logic             vld;
		logic [VAL_W-1:0] val;
	} cell_link_t;

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_SETTLE = 4'b0010,
		ST_DRAIN  = 4'b0100,
		ST_DIVW   = 4'b1000
	} state_t;

endpackage

@@ src/filtered_mean_median_mode_top.sv @@
// after the last record: a settle window, then a drain of the n stored values in ascending
// order (skipped for an empty set), then the result strobe once the mean divider is idle;
// the mean divider starts with the settle window and finishes inside it
// throughput: one record per cycle while a set is collected; busy from the last record
// until the strobe; result strobe lasts one cycle and cannot be stalled
// async active-low reset clears the key, count, sum and all cell occupancy
`timescale 1ns / 1ps
`include "filtered_mean_median_mode_top_macros.svh"

module filtered_mean_median_mode_top #(
	parameter int MAX_VALUES = fmmm_pkg::MAX_VALUES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          match_key_we,
	input  logic [fmmm_pkg::KEY_W-1:0]     match_key_wdata,
	input  logic                          start,
	output logic                          busy,
	input  logic [fmmm_pkg::KEY_W-1:0]     record_key,
	input  logic [fmmm_pkg::VAL_W-1:0]     record_value,
	input  logic                          last_record,
	output logic                          result_valid,
	output logic [fmmm_pkg::VAL_W-1:0]     mean_value,
	output logic [fmmm_pkg::VAL_W-1:0]     median_value,
	output logic [fmmm_pkg::VAL_W-1:0]     mode_value,
	output logic [fmmm_pkg::CNT_OUT_W-1:0] match_count,
	output logic                          empty_set,
	output logic                          overflowed
);

	localparam int CW = $clog2(MAX_VALUES + 1);
	localparam int TW = $clog2(MAX_VALUES + 2);

	fmmm_pkg::state_t state_q;
	logic [fmmm_pkg::KEY_W-1:0] key_q;
	logic [CW-1:0]              count_q;
	logic [fmmm_pkg::SUM_W-1:0] sum_q;
	logic                       ovf_q;
	logic [TW-1:0]              settle_q;
	logic [CW-1:0]              k_q;

	logic [fmmm_pkg::VAL_W-1:0] prev_q;
	logic [fmmm_pkg::VAL_W-1:0] lo_q;
	logic [fmmm_pkg::VAL_W-1:0] med_q;
	logic [fmmm_pkg::VAL_W-1:0] mode_q;
	logic [CW-1:0]              run_q;
	logic [CW-1:0]              best_q;

	logic                       accept;
	logic                       match;
	logic                       ins;
	logic                       shift;
	logic                       div_start;
	logic                       div_busy;
	logic [fmmm_pkg::SUM_W-1:0] quotient;
	logic [fmmm_pkg::VAL_W-1:0] d;
	logic [CW-1:0]              half;
	logic [CW-1:0]              run_nx;
	logic [fmmm_pkg::VAL_W:0]   pair_sum;

	fmmm_pkg::cell_link_t in_links   [MAX_VALUES+1];
	fmmm_pkg::cell_link_t held_links [MAX_VALUES+1];

	assign busy   = state_q != fmmm_pkg::ST_IDLE;
	assign accept = start && !busy;
	assign match  = record_key == key_q;
	assign ins    = accept && match && (count_q < CW'(MAX_VALUES));
	assign shift  = state_q == fmmm_pkg::ST_DRAIN;
	assign div_start = (state_q == fmmm_pkg::ST_SETTLE) && (settle_q == '0);

	assign in_links[0] = '{vld: ins, val: record_value};
	assign held_links[MAX_VALUES] = '0;

	generate
		for (genvar i = 0; i < MAX_VALUES; i++) begin : g_cell
			fmmm_cell u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.shift     (shift),
				.in_link   (in_links[i]),
				.nb_link   (held_links[i+1]),
				.pass_link (in_links[i+1]),
				.held_link (held_links[i])
			);
		end
	endgenerate

	fmmm_div #(
		.DW (fmmm_pkg::SUM_W),
		.NW (CW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_q),
		.divisor  (count_q),
		.busy     (div_busy),
		.quotient (quotient)
	);

	assign d        = held_links[0].val;
	assign half     = count_q >> 1;
	assign run_nx   = (d == prev_q) ? run_q + 1'b1 : CW'(1);
	assign pair_sum = {1'b0, lo_q} + {1'b0, d};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
		end else if (match_key_we) begin
			key_q <= match_key_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= fmmm_pkg::ST_IDLE;
			count_q      <= '0;
			sum_q        <= '0;
			ovf_q        <= 1'b0;
			settle_q     <= '0;
			k_q          <= '0;
			result_valid <= 1'b0;
		end else begin
			result_valid <= 1'b0;
			unique case (state_q)
				fmmm_pkg::ST_IDLE: begin
					if (accept) begin
						if (ins) begin
							count_q <= count_q + 1'b1;
							sum_q   <= sum_q + fmmm_pkg::SUM_W'(record_value);
						end else if (match) begin
							ovf_q <= 1'b1;
						end
						if (last_record) begin
							state_q  <= fmmm_pkg::ST_SETTLE;
							settle_q <= '0;
						end
					end
				end
				fmmm_pkg::ST_SETTLE: begin
					settle_q <= settle_q + 1'b1;
					if (settle_q == TW'(MAX_VALUES)) begin
						k_q     <= '0;
						state_q <= (count_q == '0) ? fmmm_pkg::ST_DIVW : fmmm_pkg::ST_DRAIN;
					end
				end
				fmmm_pkg::ST_DRAIN: begin
					k_q <= k_q + 1'b1;
					if (k_q == count_q - 1'b1) begin
						state_q <= fmmm_pkg::ST_DIVW;
					end
				end
				fmmm_pkg::ST_DIVW: begin
					if (!div_busy) begin
						result_valid <= 1'b1;
						state_q      <= fmmm_pkg::ST_IDLE;
						count_q      <= '0;
						sum_q        <= '0;
						ovf_q        <= 1'b0;
					end
				end
				default: state_q <= fmmm_pkg::ST_IDLE;
			endcase
		end
	end

	// streaming statistics over the ascending drain
	always_ff @(posedge clk) begin
		if (shift) begin
			prev_q <= d;
			if (k_q == '0) begin
				run_q  <= CW'(1);
				best_q <= CW'(1);
				mode_q <= d;
			end else begin
				run_q <= run_nx;
				if (run_nx > best_q) begin
					best_q <= run_nx;
					mode_q <= d;
				end
			end
			if (k_q == half - 1'b1) begin
				lo_q <= d;
			end
			if (k_q == half) begin
				med_q <= count_q[0] ? d : pair_sum[fmmm_pkg::VAL_W:1];
			end
		end
		if (state_q == fmmm_pkg::ST_DIVW && !div_busy) begin
			empty_set    <= count_q == '0;
			overflowed   <= ovf_q;
			match_count  <= fmmm_pkg::CNT_OUT_W'(count_q);
			mean_value   <= (count_q == '0) ? '0 : quotient[fmmm_pkg::VAL_W-1:0];
			median_value <= (count_q == '0) ? '0 : med_q;
			mode_value   <= (count_q == '0) ? '0 : mode_q;
		end
	end

	`FMMM_ASSERT(a_strobe_idle, result_valid |-> !busy, "result strobe outside idle")
	`FMMM_ASSERT(a_strobe_pulse, result_valid |=> !result_valid, "result strobe longer than one cycle")
	`FMMM_ASSERT(a_drain_full, shift |-> held_links[0].vld, "drain read an empty cell")
	`FMMM_NEVER(a_count_cap, count_q > CW'(MAX_VALUES), "stored count beyond capacity")

endmodule

@@ src/fmmm_cell.sv @@
// one cell of the insertion sorting chain: holds one value, passes the larger on
// depends on fmmm_pkg
`timescale 1ns / 1ps

module fmmm_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                shift,
	input  fmmm_pkg::cell_link_t in_link,
	input  fmmm_pkg::cell_link_t nb_link,
	output fmmm_pkg::cell_link_t pass_link,
	output fmmm_pkg::cell_link_t held_link
);

	logic                      held_vld_q;
	logic [fmmm_pkg::VAL_W-1:0] held_val_q;
	logic                      pass_vld_q;
	logic [fmmm_pkg::VAL_W-1:0] pass_val_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_vld_q <= 1'b0;
			pass_vld_q <= 1'b0;
		end else if (shift) begin
			held_vld_q <= nb_link.vld;
			pass_vld_q <= 1'b0;
		end else if (in_link.vld) begin
			held_vld_q <= 1'b1;
			pass_vld_q <= held_vld_q;
		end else begin
			pass_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			held_val_q <= nb_link.val;
		end else if (in_link.vld) begin
			if (!held_vld_q) begin
				held_val_q <= in_link.val;
			end else if (in_link.val < held_val_q) begin
				held_val_q <= in_link.val;
				pass_val_q <= held_val_q;
			end else begin
				pass_val_q <= in_link.val;
			end
		end
	end

	assign pass_link = '{vld: pass_vld_q, val: pass_val_q};
	assign held_link = '{vld: held_vld_q, val: held_val_q};

endmodule

@@ src/fmmm_div.sv @@
// restoring divider, one quotient bit per cycle
// no package dependencies
`timescale 1ns / 1ps

module fmmm_div #(
	parameter int DW = 40,
	parameter int NW = 9
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [NW-1:0] divisor,
	output logic          busy,
	output logic [DW-1:0] quotient
);

	localparam int SW = $clog2(DW + 1);

	logic [SW-1:0] step_q;
	logic [DW-1:0] dvd_q;
	logic [NW-1:0] rem_q;
	logic [NW-1:0] dsr_q;
	logic [NW:0]   trial;
	logic          fits;

	assign trial = {rem_q, dvd_q[DW-1]};
	assign fits  = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (start) begin
			step_q <= SW'(DW);
		end else if (step_q != '0) begin
			step_q <= step_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (step_q != '0) begin
			dvd_q <= {dvd_q[DW-2:0], fits};
			rem_q <= fits ? NW'(trial - {1'b0, dsr_q}) : NW'(trial);
		end
	end

	assign busy     = step_q != '0;
	assign quotient = dvd_q;

endmodule

@@ verif/fmmm_checker.sv @@
// checker for the filtered mean/median/mode block: watches the record and result
// channels, predicts each result and compares it; depends on fmmm_pkg
`timescale 1ns / 1ps

module fmmm_checker #(
	parameter int MAX_VALUES = fmmm_pkg::MAX_VALUES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          match_key_we,
	input  logic [fmmm_pkg::KEY_W-1:0]     match_key_wdata,
	input  logic                          start,
	input  logic                          busy,
	input  logic [fmmm_pkg::KEY_W-1:0]     record_key,
	input  logic [fmmm_pkg::VAL_W-1:0]     record_value,
	input  logic                          last_record,
	input  logic                          result_valid,
	input  logic [fmmm_pkg::VAL_W-1:0]     mean_value,
	input  logic [fmmm_pkg::VAL_W-1:0]     median_value,
	input  logic [fmmm_pkg::VAL_W-1:0]     mode_value,
	input  logic [fmmm_pkg::CNT_OUT_W-1:0] match_count,
	input  logic                          empty_set,
	input  logic                          overflowed,
	output int                            errors,
	output int                            pending
);
	import fmmm_pkg::*;

	typedef struct packed {
		logic [VAL_W-1:0]     mean;
		logic [VAL_W-1:0]     median;
		logic [VAL_W-1:0]     mode;
		logic [CNT_OUT_W-1:0] count;
		logic                 empty;
		logic                 ovf;
	} stats_t;

	logic [KEY_W-1:0] key_sel;
	logic [VAL_W-1:0] kept [$];
	logic [SUM_W-1:0] sum_acc;
	logic             dropped;
	stats_t           stats_q [$];

	function automatic stats_t compute_stats();
		stats_t s;
		logic [VAL_W-1:0] v [$];
		logic [VAL_W:0] pair;
		int n, run, best;
		v = kept;
		v.sort();
		n = v.size();
		s = '0;
		s.count = n[CNT_OUT_W-1:0];
		s.empty = (n == 0);
		s.ovf = dropped;
		if (n > 0) begin
			s.mean = VAL_W'(sum_acc / n);
			if (n % 2 == 0) begin
				pair = {1'b0, v[n/2-1]} + {1'b0, v[n/2]};
				s.median = pair[VAL_W:1];
			end else begin
				s.median = v[n/2];
			end
			s.mode = v[0];
			run = 1;
			best = 1;
			for (int i = 1; i < n; i++) begin
				run = (v[i] == v[i-1]) ? run + 1 : 1;
				if (run > best) begin
					best = run;
					s.mode = v[i];
				end
			end
		end
		return s;
	endfunction

	assign pending = stats_q.size();

	always @(posedge clk or negedge arst_n) begin
		stats_t got, want;
		if (!arst_n) begin
			key_sel = '0;
			kept.delete();
			sum_acc = '0;
			dropped = 1'b0;
			stats_q.delete();
			errors = 0;
		end else begin
			// result first: it belongs to an earlier set
			if (result_valid) begin
				got = '{mean_value, median_value, mode_value, match_count, empty_set,
					overflowed};
				if (stats_q.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected result %h", got);
				end else begin
					want = stats_q.pop_front();
					if (got !== want) begin
						errors++;
						if (errors <= 10)
							$display("mismatch: exp mean %h med %h mode %h cnt %0d e %b o %b, act mean %h med %h mode %h cnt %0d e %b o %b",
								want.mean, want.median, want.mode, want.count, want.empty,
								want.ovf, got.mean, got.median, got.mode, got.count,
								got.empty, got.ovf);
					end
				end
			end
			if (start && !busy) begin
				if (record_key == key_sel) begin
					if (kept.size() < MAX_VALUES) begin
						kept.push_back(record_value);
						sum_acc = sum_acc + record_value;
					end else begin
						dropped = 1'b1;
					end
				end
				if (last_record) begin
					stats_q.push_back(compute_stats());
					kept.delete();
					sum_acc = '0;
					dropped = 1'b0;
				end
			end
			if (match_key_we)
				key_sel = match_key_wdata;
		end
	end
endmodule

@@ verif/tb.sv @@
// testbench top: drives records and key writes into filtered_mean_median_mode_top
// depends on fmmm_pkg, the block and fmmm_checker
`timescale 1ns / 1ps

module tb;
	import fmmm_pkg::*;

	localparam int MAXV = MAX_VALUES_DEF;
	localparam int WATCHDOG = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic match_key_we = 1'b0;
	logic [KEY_W-1:0] match_key_wdata = '0;
	logic start = 1'b0;
	logic busy;
	logic [KEY_W-1:0] record_key = '0;
	logic [VAL_W-1:0] record_value = '0;
	logic last_record = 1'b0;
	logic result_valid;
	logic [VAL_W-1:0] mean_value, median_value, mode_value;
	logic [CNT_OUT_W-1:0] match_count;
	logic empty_set, overflowed;
	int errors, pending;
	int idle_pct = 0;
	int quiet = 0;
	logic [KEY_W-1:0] cur_key = '0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	filtered_mean_median_mode_top #(.MAX_VALUES(MAXV)) u_top (.*);

	fmmm_checker #(.MAX_VALUES(MAXV)) u_chk (.*);

	// watchdog on cycles with no accepted record and no result
	always @(posedge clk) begin
		if ((start && !busy) || result_valid || !arst_n)
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= WATCHDOG) begin
			$display("[filtered_mean_median_mode_top] ERROR");
			$finish;
		end
	end

	// start stays high between back-to-back transactions; it drops in idle gaps
	task automatic send(input logic [KEY_W-1:0] k, input logic [VAL_W-1:0] v,
		input logic lst);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		record_key <= k;
		record_value <= v;
		last_record <= lst;
		@(posedge clk);
		while (busy) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic wait_drain();
		start <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (MAXV + 60) @(negedge clk);
	endtask

	task automatic set_key(input logic [KEY_W-1:0] k);
		match_key_we <= 1'b1;
		match_key_wdata <= k;
		@(negedge clk);
		match_key_we <= 1'b0;
		cur_key = k;
	endtask

	// a set of n records, most matching, values drawn from a narrow or wide pool
	task automatic random_set(input int n);
		logic [VAL_W-1:0] pool [4];
		bit narrow;
		logic [KEY_W-1:0] k;
		logic [VAL_W-1:0] v;
		narrow = $urandom_range(1);
		for (int i = 0; i < 4; i++) pool[i] = $urandom;
		for (int i = 0; i < n; i++) begin
			k = ($urandom_range(9) < 7) ? cur_key : KEY_W'($urandom);
			v = narrow ? pool[$urandom_range(3)] : VAL_W'($urandom);
			send(k, v, i == n - 1);
		end
	endtask

	initial begin
		int total;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: empty set, single, even pair at extremes, tie for mode
		send(24'h1, 32'h5, 1'b1);
		send(24'h0, 32'hFFFF_FFFF, 1'b0);
		send(24'h0, 32'hFFFF_FFFF, 1'b1);
		send(24'h0, 32'h0, 1'b1);
		send(24'h0, 32'h7, 1'b0);
		send(24'h0, 32'h3, 1'b0);
		send(24'h0, 32'h7, 1'b0);
		send(24'h0, 32'h3, 1'b0);
		send(24'h0, 32'h9, 1'b1);
		wait_drain();
		set_key(24'hFFFFFF);
		send(24'hFFFFFF, 32'h0, 1'b0);
		send(24'hFFFFFF, 32'hFFFF_FFFF, 1'b0);
		send(24'hFFFFFE, 32'h1234, 1'b0);
		send(24'h000000, 32'h1, 1'b1);
		wait_drain();
		// capacity full: overflow on the records past capacity
		set_key(24'h4A414E);
		for (int i = 0; i <= MAXV + 2; i++)
			send(cur_key, VAL_W'($urandom), i == MAXV + 2);
		wait_drain();

		total = 13 + MAXV + 3;
		for (int ph = 0; ph < 4; ph++) begin
			idle_pct = (ph == 0) ? 0 : (ph == 1) ? 64 : (ph == 2) ? 34 : 0;
			set_key((ph == 3) ? 24'h0 : KEY_W'($urandom));
			for (int s = 0; s < 15; s++) begin
				int n;
				n = ($urandom_range(19) == 0) ? $urandom_range(MAXV + 3, MAXV - 2)
					: $urandom_range(12, 1);
				random_set(n);
				total += n;
			end
			wait_drain();
		end
		while (total < 1400) begin
			int n;
			n = $urandom_range(12, 1);
			random_set(n);
			total += n;
		end
		wait_drain();

		if (errors == 0 && pending == 0)
			$display("[filtered_mean_median_mode_top] OK");
		else
			$display("[filtered_mean_median_mode_top] ERROR");
		$finish;
	end
endmodule

@@ sim.f @@
+incdir+src
src/fmmm_pkg.sv
src/fmmm_cell.sv
src/fmmm_div.sv
src/filtered_mean_median_mode_top.sv
verif/fmmm_checker.sv
verif/tb.sv
